// File: sv/sbt_pkg.sv
// ----------------------------------------------------------------------------
// sbt_pkg
// Shared types and constants of the s-expression byte tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package sbt_pkg;

   localparam int unsigned POS_W  = 16;
   localparam int unsigned KIND_W = 3;

   localparam logic [KIND_W-1:0] KIND_COLON  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_RPAREN = 3'd1;
   localparam logic [KIND_W-1:0] KIND_LPAREN = 3'd2;
   localparam logic [KIND_W-1:0] KIND_QUOTE  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_INT    = 3'd4;
   localparam logic [KIND_W-1:0] KIND_IDENT  = 3'd5;
   localparam logic [KIND_W-1:0] KIND_END    = 3'd6;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_END  = 1'b1;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [POS_W-1:0]  start;
      logic [POS_W-1:0]  length;
      logic              last;
   } sbt_token_type;

   // tokens caused by one item: tok_a always, tok_b when two is set
   typedef struct packed {
      sbt_token_type tok_a;
      sbt_token_type tok_b;
      logic          two;
   } sbt_event_type;

endpackage

`default_nettype wire

// File: sv/sbt_front.sv
// ----------------------------------------------------------------------------
// sbt_front
// Accepts bytes, classifies them and tracks the open run; emits one event
// holding the one or two tokens an item causes.
// ----------------------------------------------------------------------------
`default_nettype none

module sbt_front #(
   parameter longint unsigned TEXT_LEN_MAX = 65536
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_push,
   input  wire logic                  in_command,
   input  wire logic [7:0]            in_byte,
   input  wire logic                  q_full,
   output logic                       ev_push,
   output sbt_pkg::sbt_event_type     ev_data
);

   localparam logic [sbt_pkg::POS_W-1:0] POS_MAX =
      (TEXT_LEN_MAX - 1 > 64'd65535) ? 16'hFFFF : 16'(TEXT_LEN_MAX - 1);

   localparam logic [1:0] MODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_INT   = 2'd1;
   localparam logic [1:0] MODE_IDENT = 2'd2;

   logic [1:0]                mode_ff, mode_in;
   logic [sbt_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [sbt_pkg::POS_W-1:0] open_ff, open_in;

   logic                      accept;
   logic                      run_emit, one_emit;
   sbt_pkg::sbt_token_type    run_tok, one_tok;
   logic [sbt_pkg::POS_W-1:0] run_len;
   logic [1:0]                mode;
   logic                      is_digit, is_space, is_punct;
   logic [sbt_pkg::KIND_W-1:0] punct_kind;

   assign accept = in_push && !q_full;

   always_comb begin
      is_punct   = 1'b1;
      punct_kind = sbt_pkg::KIND_COLON;
      unique case (in_byte)
         8'h3A:   punct_kind = sbt_pkg::KIND_COLON;
         8'h29:   punct_kind = sbt_pkg::KIND_RPAREN;
         8'h28:   punct_kind = sbt_pkg::KIND_LPAREN;
         8'h27:   punct_kind = sbt_pkg::KIND_QUOTE;
         default: is_punct = 1'b0;
      endcase
   end

   assign is_digit = (in_byte >= 8'h30) && (in_byte <= 8'h39);
   assign is_space = (in_byte == 8'h20) || (in_byte == 8'h0A) || (in_byte == 8'h0D) ||
                     (in_byte == 8'h09) || (in_byte == 8'h0B);
   assign run_len  = (pos_ff >= open_ff) ? pos_ff - open_ff : '0;

   always_comb begin
      mode     = (mode_ff == MODE_INT || mode_ff == MODE_IDENT) ? mode_ff : MODE_IDLE;
      mode_in  = mode;
      pos_in   = pos_ff;
      open_in  = open_ff;
      run_emit = 1'b0;
      one_emit = 1'b0;
      run_tok.kind   = (mode == MODE_INT) ? sbt_pkg::KIND_INT : sbt_pkg::KIND_IDENT;
      run_tok.start  = open_ff;
      run_tok.length = run_len;
      run_tok.last   = 1'b0;
      one_tok.kind   = punct_kind;
      one_tok.start  = pos_ff;
      one_tok.length = 16'd1;
      one_tok.last   = 1'b1;
      if (in_command == sbt_pkg::CMD_END) begin
         run_emit       = (mode != MODE_IDLE);
         one_emit       = 1'b1;
         one_tok.kind   = sbt_pkg::KIND_END;
         one_tok.start  = (pos_ff != '0) ? pos_ff - 16'd1 : '0;
         one_tok.length = '0;
         mode_in        = MODE_IDLE;
         pos_in         = '0;
         open_in        = '0;
      end else begin
         if ((mode == MODE_INT && !is_digit) ||
             (mode == MODE_IDENT && (is_punct || is_space))) begin
            run_emit = 1'b1;
            mode_in  = MODE_IDLE;
         end
         if (mode_in == MODE_IDLE) begin
            if (is_punct) begin
               one_emit = 1'b1;
            end else if (!is_space) begin
               mode_in = is_digit ? MODE_INT : MODE_IDENT;
               open_in = pos_ff;
            end
         end
         if (pos_ff < POS_MAX) begin
            pos_in = pos_ff + 16'd1;
         end
      end
   end

   always_comb begin
      ev_data.tok_b = one_tok;
      if (run_emit) begin
         ev_data.tok_a      = run_tok;
         ev_data.tok_a.last = !one_emit;
         ev_data.two        = one_emit;
      end else begin
         ev_data.tok_a = one_tok;
         ev_data.two   = 1'b0;
      end
   end

   assign ev_push = accept && (run_emit || one_emit);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         pos_ff  <= '0;
         open_ff <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         pos_ff  <= pos_in;
         open_ff <= open_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/sbt_queue.sv
// ----------------------------------------------------------------------------
// sbt_queue
// Short event queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module sbt_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  sbt_pkg::sbt_event_type     wdata,
   input  wire logic                  pop,
   output sbt_pkg::sbt_event_type     rdata,
   output logic                       full,
   output logic                       valid
);

   localparam int unsigned DEPTH = 4;
   localparam int unsigned PTR_W = $clog2(DEPTH);

   sbt_pkg::sbt_event_type mem_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]         count_ff;
   logic                   do_push, do_pop;

   assign full    = (count_ff == (PTR_W+1)'(DEPTH));
   assign valid   = (count_ff != '0);
   assign do_push = push && !full;
   assign do_pop  = pop && valid;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
      end
   end

endmodule

`default_nettype wire

// File: sv/sbt_back.sv
// ----------------------------------------------------------------------------
// sbt_back
// Expands events into single tokens and holds the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sbt_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  sbt_pkg::sbt_event_type     ev_data,
   input  wire logic                  ev_valid,
   output logic                       ev_pop,
   input  wire logic                  out_pop,
   output logic                       out_valid,
   output sbt_pkg::sbt_token_type     out_tok
);

   logic                   out_valid_ff;
   sbt_pkg::sbt_token_type out_tok_ff;
   logic                   pend_ff;
   sbt_pkg::sbt_token_type pend_tok_ff;
   logic                   load;

   assign load      = !out_valid_ff || out_pop;
   assign ev_pop    = load && !pend_ff && ev_valid;
   assign out_valid = out_valid_ff;
   assign out_tok   = out_tok_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         if (pend_ff) begin
            out_tok_ff <= pend_tok_ff;
         end else begin
            out_tok_ff  <= ev_data.tok_a;
            pend_tok_ff <= ev_data.tok_b;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else if (load) begin
         if (pend_ff) begin
            out_valid_ff <= 1'b1;
            pend_ff      <= 1'b0;
         end else begin
            out_valid_ff <= ev_valid;
            pend_ff      <= ev_valid && ev_data.two;
         end
      end
   end

endmodule

`default_nettype wire

// File: sv/sexpr_byte_tokenizer.sv
// ----------------------------------------------------------------------------
// sexpr_byte_tokenizer
// S-expression lexer: bytes in, (kind, start, length) tokens out.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | accepted when
//  ---------+-----------------------------------------+----------------------
//  request  | req_push req_full req_command req_data_byte | push && !full
//  response | rsp_empty rsp_pop rsp_token_* rsp_run_last  | pop && !empty
//
//  One item per cycle is accepted while the queue is not full; the front updates the
//  scan state in the cycle of acceptance and queues the item's tokens (none, one or two).
//  The back emits one token per cycle while the receiver pops, so items causing two
//  tokens drain at that rate; the 4-entry event queue and full set back-pressure.
//  An item's tokens reach the ports through the event queue and then the output register.
//  Reset is synchronous and clears scan state, queue and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sexpr_byte_tokenizer #(
   parameter longint unsigned TEXT_LEN_MAX = 65536
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic        req_command,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [2:0]       rsp_token_kind,
   output logic [15:0]      rsp_token_start,
   output logic [15:0]      rsp_token_length,
   output logic             rsp_run_last
);

   sbt_pkg::sbt_event_type ev_wdata, ev_rdata;
   sbt_pkg::sbt_token_type out_tok;
   logic                   ev_push, ev_pop, q_full, q_valid, out_valid;

   sbt_front #(.TEXT_LEN_MAX(TEXT_LEN_MAX)) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_push    (req_push),
      .in_command (req_command),
      .in_byte    (req_data_byte),
      .q_full     (q_full),
      .ev_push    (ev_push),
      .ev_data    (ev_wdata)
   );

   sbt_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (ev_push),
      .wdata (ev_wdata),
      .pop   (ev_pop),
      .rdata (ev_rdata),
      .full  (q_full),
      .valid (q_valid)
   );

   sbt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .ev_data   (ev_rdata),
      .ev_valid  (q_valid),
      .ev_pop    (ev_pop),
      .out_pop   (rsp_pop),
      .out_valid (out_valid),
      .out_tok   (out_tok)
   );

   assign req_full         = q_full;
   assign rsp_empty        = !out_valid;
   assign rsp_token_kind   = out_tok.kind;
   assign rsp_token_start  = out_tok.start;
   assign rsp_token_length = out_tok.length;
   assign rsp_run_last     = out_tok.last;

endmodule

`default_nettype wire

// File: dv/sexpr_byte_tokenizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sexpr_byte_tokenizer_tb
// Self-checking bench for the s-expression byte tokenizer. Bytes and
// end-of-text items go in through the push/full queue side. A scoreboard
// class runs its own lexer on every accepted item and queues the tokens it
// predicts. Each popped token is matched field by field against the oldest
// one. The stimulus is a directed text and random texts built from tokens
// plus noise.
// The sender works in bursts and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------

module sexpr_byte_tokenizer_tb;

   localparam int             CYCLE_LIMIT  = 1_000_000;
   localparam int             RANDOM_ITEMS = 800;
   localparam logic [15:0]    POS_MAX      = 16'hFFFF;

   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_QUOTE  = 8'h27;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_VT     = 8'h0B;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   localparam int POP_ALWAYS = 0;
   localparam int POP_COIN   = 1;
   localparam int POP_MASK   = 2;
   localparam int POP_SPARSE = 3;

   typedef enum logic [1:0] {SCAN_IDLE, SCAN_INT, SCAN_IDENT} scan_mode_type;
   typedef enum {PIECE_PUNCT, PIECE_SPACE, PIECE_DIGIT, PIECE_WORD, PIECE_NOISE} piece_type;

   class lexer_scoreboard;
      scan_mode_type          mode;
      logic [15:0]            pos;
      logic [15:0]            open_start;
      sbt_pkg::sbt_token_type expected_tokens[$];
      int                     errors;

      function new();
         mode       = SCAN_IDLE;
         pos        = '0;
         open_start = '0;
         errors     = 0;
      endfunction

      function int pending();
         return expected_tokens.size();
      endfunction

      // token of the open run, ending just before offset stop
      function sbt_pkg::sbt_token_type run_token(logic [15:0] stop);
         sbt_pkg::sbt_token_type t;
         t.kind   = (mode == SCAN_INT) ? sbt_pkg::KIND_INT : sbt_pkg::KIND_IDENT;
         t.start  = open_start;
         t.length = (stop >= open_start) ? stop - open_start : 16'd0;
         t.last   = 1'b0;
         return t;
      endfunction

      function void note_item(logic cmd, logic [7:0] ch);
         sbt_pkg::sbt_token_type toks[2];
         int                     n;
         logic [2:0]             pk;
         bit                     punct;
         bit                     ws;
         bit                     digit;
         n = 0;
         if (cmd == sbt_pkg::CMD_END) begin
            if (mode != SCAN_IDLE) begin
               toks[n] = run_token(pos);
               n++;
            end
            toks[n] = {sbt_pkg::KIND_END, (pos != 16'd0) ? pos - 16'd1 : 16'd0,
                       16'd0, 1'b0};
            n++;
            mode       = SCAN_IDLE;
            pos        = '0;
            open_start = '0;
         end else begin
            punct = 1'b1;
            case (ch)
               CH_COLON:  pk = sbt_pkg::KIND_COLON;
               CH_RPAREN: pk = sbt_pkg::KIND_RPAREN;
               CH_LPAREN: pk = sbt_pkg::KIND_LPAREN;
               CH_QUOTE:  pk = sbt_pkg::KIND_QUOTE;
               default: begin
                  pk    = sbt_pkg::KIND_END;
                  punct = 1'b0;
               end
            endcase
            ws = (ch == CH_SPACE) || (ch == CH_LF) || (ch == CH_CR) ||
                 (ch == CH_TAB) || (ch == CH_VT);
            digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
            if (mode == SCAN_INT && !digit) begin
               toks[n] = run_token(pos);
               n++;
               mode = SCAN_IDLE;
            end else if (mode == SCAN_IDENT && (punct || ws)) begin
               toks[n] = run_token(pos);
               n++;
               mode = SCAN_IDLE;
            end
            if (mode == SCAN_IDLE) begin
               if (punct) begin
                  toks[n] = {pk, pos, 16'd1, 1'b0};
                  n++;
               end else if (!ws) begin
                  mode       = digit ? SCAN_INT : SCAN_IDENT;
                  open_start = pos;
               end
            end
            if (pos != POS_MAX)
               pos++;
         end
         if (n > 0)
            toks[n-1].last = 1'b1;
         for (int i = 0; i < n; i++)
            expected_tokens.push_back(toks[i]);
      endfunction

      function void check_token(sbt_pkg::sbt_token_type got);
         sbt_pkg::sbt_token_type want;
         if (expected_tokens.size() == 0) begin
            errors++;
            $display("%0t: unexpected token, expected none, actual kind %0d start %0d",
                     $time, got.kind, got.start);
            $display("%0t: unexpected token, actual length %0d last %0d",
                     $time, got.length, got.last);
            return;
         end
         want = expected_tokens.pop_front();
         if (got.kind !== want.kind) begin
            errors++;
            $display("%0t: token_kind expected %0d actual %0d", $time, want.kind, got.kind);
         end
         if (got.start !== want.start) begin
            errors++;
            $display("%0t: token_start expected %0d actual %0d", $time, want.start, got.start);
         end
         if (got.length !== want.length) begin
            errors++;
            $display("%0t: token_length expected %0d actual %0d", $time, want.length,
                     got.length);
         end
         if (got.last !== want.last) begin
            errors++;
            $display("%0t: run_last expected %0d actual %0d", $time, want.last, got.last);
         end
      endfunction
   endclass

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_push      = 1'b0;
   logic        req_full;
   logic        req_command   = sbt_pkg::CMD_BYTE;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_empty;
   logic        rsp_pop       = 1'b0;
   logic [2:0]  rsp_token_kind;
   logic [15:0] rsp_token_start;
   logic [15:0] rsp_token_length;
   logic        rsp_run_last;

   lexer_scoreboard sb;
   int          cycle_count = 0;
   int          items_sent  = 0;
   int          burst_left  = 0;
   bit          pace        = 1'b0;
   int          pop_style   = POP_ALWAYS;
   int          style_left  = 0;
   logic [7:0]  pop_mask    = 8'hFF;
   logic [7:0]  pop_phase   = 8'h00;

   sexpr_byte_tokenizer uut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_command      (req_command),
      .req_data_byte    (req_data_byte),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_start  (rsp_token_start),
      .rsp_token_length (rsp_token_length),
      .rsp_run_last     (rsp_run_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // accepted items and tokens, sampled with pre-edge values
   always @(posedge clock) begin
      if (!reset && req_push && !req_full)
         sb.note_item(req_command, req_data_byte);
      if (!reset && rsp_pop && !rsp_empty)
         sb.check_token({rsp_token_kind, rsp_token_start, rsp_token_length, rsp_run_last});
   end

   always @(posedge clock) begin
      if (style_left == 0) begin
         pop_style  = $urandom_range(POP_ALWAYS, POP_SPARSE);
         style_left = $urandom_range(16, 128);
         pop_mask   = 8'($urandom) | 8'h01;
      end
      style_left--;
      pop_phase++;
      case (pop_style)
         POP_ALWAYS: rsp_pop <= !reset;
         POP_COIN:   rsp_pop <= !reset && ($urandom_range(0, 1) == 1);
         POP_MASK:   rsp_pop <= !reset && pop_mask[pop_phase[2:0]];
         default:    rsp_pop <= !reset && (pop_phase[1:0] == 2'd0);
      endcase
   end

   function automatic logic [7:0] pick_char(piece_type piece);
      logic [7:0] c;
      case (piece)
         PIECE_PUNCT: begin
            case ($urandom_range(0, 3))
               0:       c = CH_COLON;
               1:       c = CH_RPAREN;
               2:       c = CH_LPAREN;
               default: c = CH_QUOTE;
            endcase
         end
         PIECE_SPACE: begin
            case ($urandom_range(0, 4))
               0:       c = CH_SPACE;
               1:       c = CH_LF;
               2:       c = CH_CR;
               3:       c = CH_TAB;
               default: c = CH_VT;
            endcase
         end
         PIECE_DIGIT: c = CH_ZERO + 8'($urandom_range(0, 9));
         PIECE_WORD: begin
            do
               c = 8'($urandom_range(0, 255));
            while (c == CH_COLON || c == CH_RPAREN || c == CH_LPAREN || c == CH_QUOTE ||
                   c == CH_SPACE || c == CH_LF || c == CH_CR || c == CH_TAB ||
                   c == CH_VT || (c >= CH_ZERO && c <= CH_NINE));
         end
         default: c = 8'($urandom_range(0, 255));
      endcase
      return c;
   endfunction

   task automatic send(input logic cmd, input logic [7:0] ch);
      int gap;
      if (pace && burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = $urandom_range(0, 6);
         if (gap != 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      if (burst_left > 0)
         burst_left--;
      req_push      <= 1'b1;
      req_command   <= cmd;
      req_data_byte <= ch;
      do
         @(posedge clock);
      while (req_full !== 1'b0);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   // well-formed tokens with random content, some noise, then end of text
   task automatic send_text();
      int pieces;
      int run;
      pieces = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
      repeat (pieces) begin
         case ($urandom_range(0, 9))
            0, 1: send(sbt_pkg::CMD_BYTE, pick_char(PIECE_PUNCT));
            2, 3: begin
               run = $urandom_range(1, 5);
               repeat (run) send(sbt_pkg::CMD_BYTE, pick_char(PIECE_DIGIT));
            end
            4, 5, 6: begin
               send(sbt_pkg::CMD_BYTE, pick_char(PIECE_WORD));
               run = $urandom_range(0, 5);
               repeat (run)
                  send(sbt_pkg::CMD_BYTE,
                       pick_char(($urandom_range(0, 2) == 0) ? PIECE_DIGIT : PIECE_WORD));
            end
            7, 8: begin
               run = $urandom_range(1, 3);
               repeat (run) send(sbt_pkg::CMD_BYTE, pick_char(PIECE_SPACE));
            end
            default: send(sbt_pkg::CMD_BYTE, pick_char(PIECE_NOISE));
         endcase
      end
      send(sbt_pkg::CMD_END, 8'($urandom_range(0, 255)));
   endtask

   initial begin
      int mark;
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // every token kind, each way a run closes, zero and 0xFF bytes
      send(sbt_pkg::CMD_BYTE, CH_LPAREN);
      send(sbt_pkg::CMD_BYTE, "1");
      send(sbt_pkg::CMD_BYTE, "2");
      send(sbt_pkg::CMD_BYTE, "x");
      send(sbt_pkg::CMD_BYTE, CH_NINE);
      send(sbt_pkg::CMD_BYTE, CH_SPACE);
      send(sbt_pkg::CMD_BYTE, "a");
      send(sbt_pkg::CMD_BYTE, CH_LF);
      send(sbt_pkg::CMD_BYTE, CH_ZERO);
      send(sbt_pkg::CMD_BYTE, CH_RPAREN);
      send(sbt_pkg::CMD_BYTE, CH_TAB);
      send(sbt_pkg::CMD_BYTE, 8'h00);
      send(sbt_pkg::CMD_BYTE, CH_COLON);
      send(sbt_pkg::CMD_BYTE, CH_CR);
      send(sbt_pkg::CMD_BYTE, CH_QUOTE);
      send(sbt_pkg::CMD_BYTE, CH_VT);
      send(sbt_pkg::CMD_BYTE, 8'hFF);
      send(sbt_pkg::CMD_BYTE, "7");
      send(sbt_pkg::CMD_END, 8'h00);
      send(sbt_pkg::CMD_END, 8'hFF);
      send(sbt_pkg::CMD_BYTE, "5");
      send(sbt_pkg::CMD_END, 8'h5A);
      wait_drained();

      pace = 1'b1;
      mark = items_sent;
      while (items_sent - mark < RANDOM_ITEMS) begin
         send_text();
         if ($urandom_range(0, 15) == 0)
            wait_drained();
      end
      wait_drained();
      repeat (20) @(posedge clock);

      if (sb.errors == 0 && sb.pending() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
